// ===== rtl/core/tbsf_pkg.sv =====
// Shared types and constants of the telegram byte-stuffing framer.
`timescale 1ns / 1ps
`default_nettype none
package tbsf_pkg;

  localparam logic [7:0] MARK_START = 8'hAA;
  localparam logic [7:0] MARK_END   = 8'hBB;
  localparam logic [7:0] MARK_ESC   = 8'hCC;

  localparam logic [7:0] TYPE_VALUE  = 8'h01;
  localparam logic [7:0] TYPE_STRING = 8'h02;

  localparam int unsigned SEQ_LEN = 11;
  localparam int unsigned CNT_W   = $clog2(SEQ_LEN + 1);

  typedef enum logic [1:0] {
    CMD_OPEN_VALUE  = 2'd0,
    CMD_OPEN_STRING = 2'd1,
    CMD_TEXT        = 2'd2,
    CMD_CLOSE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STRING = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_OPEN_VALUE   = 3'd0,
    OP_OPEN_STRING  = 3'd1,
    OP_TEXT         = 3'd2,
    OP_CLOSE_VALUE  = 3'd3,
    OP_CLOSE_STRING = 3'd4
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [7:0]  text_byte;
    logic [1:0]  value_type;
    logic [31:0] value_word;
    logic [31:0] time_stamp;
  } job_t;

  typedef struct packed {
    logic       raw;
    logic [7:0] data;
  } seq_elem_t;

  function automatic logic needs_stuff(input logic [7:0] b);
    return (b == MARK_START) || (b == MARK_END) || (b == MARK_ESC);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tbsf_front.sv =====
// Front end: accepts command requests, tracks the open telegram, issues jobs.
`timescale 1ns / 1ps
`default_nettype none
module tbsf_front
  import tbsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic [1:0]  value_type_i,
  input  wire logic [31:0] value_word_i,
  input  wire logic [31:0] time_stamp_i,
  input  wire logic        queue_full_i,
  output logic             push_o,
  output job_t             job_o
);

  kind_e open_kind_q, open_kind_d;
  logic  accept;
  logic  issue;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  always_comb begin
    open_kind_d      = open_kind_q;
    issue            = 1'b1;
    job_o.op         = OP_TEXT;
    job_o.text_byte  = text_byte_i;
    job_o.value_type = value_type_i;
    job_o.value_word = value_word_i;
    job_o.time_stamp = time_stamp_i;
    unique case (cmd_e'(command_i))
      CMD_OPEN_VALUE: begin
        job_o.op    = OP_OPEN_VALUE;
        open_kind_d = KIND_VALUE;
      end
      CMD_OPEN_STRING: begin
        job_o.op    = OP_OPEN_STRING;
        open_kind_d = KIND_STRING;
      end
      CMD_TEXT: begin
        job_o.op = OP_TEXT;
        issue    = (open_kind_q != KIND_NONE);
      end
      CMD_CLOSE: begin
        open_kind_d = KIND_NONE;
        if (open_kind_q == KIND_VALUE) begin
          job_o.op = OP_CLOSE_VALUE;
        end else if (open_kind_q == KIND_STRING) begin
          job_o.op = OP_CLOSE_STRING;
        end else begin
          issue = 1'b0;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign push_o = accept && issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_kind_q <= KIND_NONE;
    end else if (accept) begin
      open_kind_q <= open_kind_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tbsf_queue.sv =====
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tbsf_queue
  import tbsf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output job_t      head_job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  job_t              slots_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o       = (count_q == FULL_CNT);
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tbsf_back.sv =====
// Back end: expands a job into wire bytes, stuffs content, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module tbsf_back
  import tbsf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire job_t       head_job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  seq_elem_t        seq_q [SEQ_LEN];
  seq_elem_t        seq_d [SEQ_LEN];
  seq_elem_t        build [SEQ_LEN];
  seq_elem_t        cur   [SEQ_LEN];
  logic [CNT_W-1:0] cnt_q, cnt_d, build_cnt, cur_cnt;
  logic             esc_pend_q, esc_pend_d;
  logic [7:0]       esc_byte_q, esc_byte_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_ready;
  logic             busy;
  logic [7:0]       type_id;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign busy      = (cnt_q != '0);
  assign type_id   = {6'd0, head_job_i.value_type} + 8'd1;

  always_comb begin
    for (int i = 0; i < SEQ_LEN; i++) begin
      build[i] = '{raw: 1'b0, data: 8'h00};
    end
    build_cnt = '0;
    unique case (head_job_i.op)
      OP_OPEN_VALUE: begin
        build[0]  = '{raw: 1'b1, data: MARK_START};
        build[1]  = '{raw: 1'b0, data: TYPE_VALUE};
        build_cnt = CNT_W'(2);
      end
      OP_OPEN_STRING: begin
        build[0]  = '{raw: 1'b1, data: MARK_START};
        build[1]  = '{raw: 1'b0, data: TYPE_STRING};
        build_cnt = CNT_W'(2);
      end
      OP_TEXT: begin
        build[0]  = '{raw: 1'b0, data: head_job_i.text_byte};
        build_cnt = CNT_W'(1);
      end
      OP_CLOSE_STRING: begin
        build[0]  = '{raw: 1'b0, data: 8'h00};
        build[1]  = '{raw: 1'b1, data: MARK_END};
        build_cnt = CNT_W'(2);
      end
      OP_CLOSE_VALUE: begin
        build[0] = '{raw: 1'b0, data: 8'h00};
        build[1] = '{raw: 1'b0, data: type_id};
        if (!head_job_i.value_type[1]) begin
          build[2] = '{raw: 1'b0, data: head_job_i.value_word[7:0]};
          for (int i = 0; i < 4; i++) begin
            build[3 + i] = '{raw: 1'b0, data: head_job_i.time_stamp[8*i +: 8]};
          end
          build[7]  = '{raw: 1'b1, data: MARK_END};
          build_cnt = CNT_W'(8);
        end else begin
          for (int i = 0; i < 4; i++) begin
            build[2 + i] = '{raw: 1'b0, data: head_job_i.value_word[8*i +: 8]};
            build[6 + i] = '{raw: 1'b0, data: head_job_i.time_stamp[8*i +: 8]};
          end
          build[10] = '{raw: 1'b1, data: MARK_END};
          build_cnt = CNT_W'(11);
        end
      end
      default: begin
        build_cnt = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < SEQ_LEN; i++) begin
      cur[i] = busy ? seq_q[i] : build[i];
    end
    if (busy) begin
      cur_cnt = cnt_q;
    end else if (head_valid_i && !esc_pend_q) begin
      cur_cnt = build_cnt;
    end else begin
      cur_cnt = '0;
    end
  end

  assign pop_o = out_ready && !esc_pend_q && !busy && head_valid_i;

  always_comb begin
    for (int i = 0; i < SEQ_LEN; i++) begin
      seq_d[i] = seq_q[i];
    end
    cnt_d       = cnt_q;
    esc_pend_d  = esc_pend_q;
    esc_byte_d  = esc_byte_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_ready) begin
      out_valid_d = 1'b0;
      if (esc_pend_q) begin
        out_valid_d = 1'b1;
        out_byte_d  = esc_byte_q;
        out_last_d  = (cnt_q == '0);
        esc_pend_d  = 1'b0;
      end else if (cur_cnt != '0) begin
        out_valid_d = 1'b1;
        if (!cur[0].raw && needs_stuff(cur[0].data)) begin
          out_byte_d = MARK_ESC;
          out_last_d = 1'b0;
          esc_pend_d = 1'b1;
          esc_byte_d = cur[0].data - 8'd1;
        end else begin
          out_byte_d = cur[0].data;
          out_last_d = (cur_cnt == CNT_W'(1));
        end
        for (int i = 0; i < SEQ_LEN - 1; i++) begin
          seq_d[i] = cur[i + 1];
        end
        seq_d[SEQ_LEN - 1] = cur[SEQ_LEN - 1];
        cnt_d = cur_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SEQ_LEN; i++) begin
      seq_q[i] <= seq_d[i];
    end
    esc_byte_q <= esc_byte_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      esc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      esc_pend_q  <= esc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/telegram_byte_stuffing_framer.sv =====
// Top level of the telegram byte-stuffing framer.
//
// Input channel: one command request per accepted item (open value, open
// string, text byte, close) with its text, value and timestamp fields.
// Output channel: one wire byte per accepted item on the output side, with
// last_of_run_o set on the final byte that an input request causes.
// A request is held in a queue slot and its first byte is then registered
// into the output register when the queue and output are idle.
// Throughput: one wire byte per cycle while the receiver does not stall, set
// by the output register; a request produces 1 to 19 bytes (a value close
// with every value and timestamp byte stuffed). Requests that cause no
// byte (text or close with no telegram open) are accepted but push no job.
// in_stall_o rises while the job queue (QUEUE_DEPTH entries) is full.
// Reset: no telegram open, queue empty, no byte shown.
// Receiver stall: the shown byte holds; the sequencer waits; the queue
// fills and then stalls the input side.
`timescale 1ns / 1ps
`default_nettype none
module telegram_byte_stuffing_framer
  import tbsf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic [1:0]  value_type_i,
  input  wire logic [31:0] value_word_i,
  input  wire logic [31:0] time_stamp_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  tbsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .text_byte_i  (text_byte_i),
    .value_type_i (value_type_i),
    .value_word_i (value_word_i),
    .time_stamp_i (time_stamp_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  tbsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  tbsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_job_i    (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tbsf_checker.sv =====
// Port-level checks of the telegram byte-stuffing framer and their binding.
`timescale 1ns / 1ps
`default_nettype none
module tbsf_checker
  import tbsf_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

  a_escape_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_o == MARK_ESC |-> !last_of_run_o)
    else $error("escape ends a run");

  a_end_mark_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_o == MARK_END |-> last_of_run_o)
    else $error("end mark not at end of run");

endmodule

bind telegram_byte_stuffing_framer tbsf_checker u_tbsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);
`default_nettype wire
